// ===== hdl/avcr_pkg.sv =====
// avcr_pkg: shared widths, beat types and register indexes for the
// averaged calibrated vector reading block
// no dependencies
`default_nettype none

package avcr_pkg;

    // group length and sample counter
    localparam int SAMPLES_PER_GROUP = 16;
    localparam int CNT_W             = 8;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_GROUP - 1);

    // datapath widths
    localparam int AXES    = 3;
    localparam int RAW_W   = 16;
    localparam int DIFF_W  = RAW_W + 1;
    localparam int SUM_W   = 25;
    localparam int COEF_W  = 21;
    localparam int PROD_W  = COEF_W + SUM_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CAL_W   = 32;
    localparam int ROW_W   = AXES * COEF_W;
    localparam int OFFS_W  = AXES * RAW_W;
    localparam int SHIFT_W = 6;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_ZERO  = 3'd0,
        CFG_ROW_ONE   = 3'd1,
        CFG_ROW_TWO   = 3'd2,
        CFG_OFFSETS   = 3'd3,
        CFG_SHIFT     = 3'd4
    } t_cfg_idx;

    // register reset values: identity matrix, no offsets
    localparam logic [ROW_W-1:0]   ROW_ZERO_RST = ROW_W'(1);
    localparam logic [ROW_W-1:0]   ROW_ONE_RST  = ROW_W'(1) << COEF_W;
    localparam logic [ROW_W-1:0]   ROW_TWO_RST  = ROW_W'(1) << (2 * COEF_W);
    localparam logic [SHIFT_W-1:0] SHIFT_RST    = SHIFT_W'(4);

    // input and output beats
    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [CAL_W-1:0] cal_x;
        logic signed [CAL_W-1:0] cal_y;
        logic signed [CAL_W-1:0] cal_z;
    } t_out_beat;

    // pipeline advance strobes from the top level to the row lanes
    typedef struct packed {
        logic adv_prod;
        logic adv_sum;
        logic adv_out;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== hdl/averaged_calibrated_vector_reading.sv =====
// Averaged calibrated three-axis reading. Takes one raw x/y/z sample per cycle, subtracts
// the per-axis offsets and accumulates over SAMPLES_PER_GROUP samples; the last sample of
// a group sends the three sums through a 3x3 signed matrix, an arithmetic right shift by
// r_shift and a 32-bit clamp, and one calibrated vector beat comes out. Samples are
// taken every cycle with no gap, also across group boundaries, while input ready is high;
// after the closing beat the vector passes the total, multiplier, row sum and output
// registers. The pipeline after the accumulators is fully pipelined, so groups of one
// sample still run at one beat per cycle unless the output stalls; a stalled output backs
// up through those four registers before input ready drops. Configuration is written
// through a simple write port and should change only while nothing is in flight.
// depends on avcr_pkg, avcr_lane, avcr_row
`default_nettype none

module averaged_calibrated_vector_reading
    import avcr_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_beat              i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output t_out_beat                  o_out_data,
    input  wire                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ROW_W-1:0]   r_row [AXES];
    logic [OFFS_W-1:0]  r_offs;
    logic [SHIFT_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_count;
    logic               r_v_tot;
    logic               r_v_prod;
    logic               r_v_sum;
    logic               r_v_out;

    logic               w_accept;
    logic               w_last;
    logic               w_adv_tot;
    t_pipe_ctl          w_ctl;
    logic signed [RAW_W-1:0] w_raw [AXES];
    logic signed [SUM_W-1:0] w_total [AXES];
    logic signed [CAL_W-1:0] w_cal [AXES];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_ZERO_RST;
            r_row[1] <= ROW_ONE_RST;
            r_row[2] <= ROW_TWO_RST;
            r_offs   <= '0;
            r_shift  <= SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_ZERO: r_row[0] <= i_cfg_data;
                CFG_ROW_ONE:  r_row[1] <= i_cfg_data;
                CFG_ROW_TWO:  r_row[2] <= i_cfg_data;
                CFG_OFFSETS:  r_offs   <= i_cfg_data[OFFS_W-1:0];
                CFG_SHIFT:    r_shift  <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline advance, each stage moves when the next one is free
    always_comb begin
        w_ctl.adv_out  = !r_v_out || i_out_ready;
        w_ctl.adv_sum  = !r_v_sum || w_ctl.adv_out;
        w_ctl.adv_prod = !r_v_prod || w_ctl.adv_sum;
        w_adv_tot      = !r_v_tot || w_ctl.adv_prod;
        o_in_ready     = w_adv_tot;
        w_accept       = i_in_valid && o_in_ready;
        w_last         = (r_count == LAST_COUNT);
    end

    // sample counter within a group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= w_last ? '0 : r_count + CNT_W'(1);
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_tot  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_adv_tot) begin
                r_v_tot <= w_accept && w_last;
            end
            if (w_ctl.adv_prod) begin
                r_v_prod <= r_v_tot;
            end
            if (w_ctl.adv_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (w_ctl.adv_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    assign w_raw[0] = i_in_data.raw_x;
    assign w_raw[1] = i_in_data.raw_y;
    assign w_raw[2] = i_in_data.raw_z;

    // axis lanes and matrix row lanes
    for (genvar a = 0; a < AXES; a++) begin : g_lane
        avcr_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_last   (w_last),
            .i_raw    (w_raw[a]),
            .i_offset ($signed(r_offs[RAW_W*a +: RAW_W])),
            .o_total  (w_total[a])
        );

        avcr_row u_row (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_row   (r_row[a]),
            .i_shift (r_shift),
            .i_total (w_total),
            .o_cal   (w_cal[a])
        );
    end

    assign o_out_valid      = r_v_out;
    assign o_out_data.cal_x = w_cal[0];
    assign o_out_data.cal_y = w_cal[1];
    assign o_out_data.cal_z = w_cal[2];

`ifndef SYNTHESIS
    // a beat that closes a group lands in the total stage
    a_group_to_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> r_v_tot)
        else $error("group end did not reach the total stage");

    // the counter restarts after a group end
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_count == '0))
        else $error("sample counter did not restart");

    // a full row sum stage is not lost while the output stalls
    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_sum && !w_ctl.adv_out) |=> r_v_sum)
        else $error("row sum dropped during output stall");
`endif

endmodule

`default_nettype wire

// ===== hdl/avcr_lane.sv =====
// avcr_lane: one axis lane, offset subtract and group accumulation
// depends on avcr_pkg
`default_nettype none

module avcr_lane
    import avcr_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_accept,
    input  wire                      i_last,
    input  wire logic signed [RAW_W-1:0] i_raw,
    input  wire logic signed [RAW_W-1:0] i_offset,
    output logic signed [SUM_W-1:0]  o_total
);

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_total;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SUM_W-1:0]  n_sum;

    // corrected sample added into the running sum
    always_comb begin
        w_diff = DIFF_W'(i_raw) - DIFF_W'(i_offset);
        n_sum  = r_sum + SUM_W'(w_diff);
    end

    // running sum clears after the last sample of a group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_accept) begin
            r_sum <= i_last ? '0 : n_sum;
        end
    end

    // group total held for the matrix stage
    always_ff @(posedge i_clk) begin
        if (i_accept && i_last) begin
            r_total <= n_sum;
        end
    end

    assign o_total = r_total;

endmodule

`default_nettype wire

// ===== hdl/avcr_row.sv =====
// avcr_row: one matrix row, three products, row sum, shift and saturate
// depends on avcr_pkg
`default_nettype none

module avcr_row
    import avcr_pkg::*;
(
    input  wire                      i_clk,
    input  wire t_pipe_ctl           i_ctl,
    input  wire logic [ROW_W-1:0]    i_row,
    input  wire logic [SHIFT_W-1:0]  i_shift,
    input  wire logic signed [SUM_W-1:0] i_total [AXES],
    output logic signed [CAL_W-1:0]  o_cal
);

    logic signed [COEF_W-1:0] w_coef [AXES];
    logic signed [PROD_W-1:0] w_prod [AXES];
    logic signed [PROD_W-1:0] r_prod [AXES];
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_shifted;
    logic signed [CAL_W-1:0]  n_cal;
    logic signed [CAL_W-1:0]  r_cal;

    // coefficient times group total, one multiplier per column
    always_comb begin
        for (int c = 0; c < AXES; c++) begin
            w_coef[c] = $signed(i_row[COEF_W*c +: COEF_W]);
            w_prod[c] = w_coef[c] * i_total[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_prod) begin
            for (int c = 0; c < AXES; c++) begin
                r_prod[c] <= w_prod[c];
            end
        end
    end

    // row sum
    always_comb begin
        w_acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_sum) begin
            r_acc <= w_acc;
        end
    end

    // arithmetic shift, then clamp to 32 bits
    always_comb begin
        w_shifted = r_acc >>> i_shift;
        if (&w_shifted[ACC_W-1:CAL_W-1] || ~|w_shifted[ACC_W-1:CAL_W-1]) begin
            n_cal = w_shifted[CAL_W-1:0];
        end else if (w_shifted[ACC_W-1]) begin
            n_cal = {1'b1, {(CAL_W-1){1'b0}}};
        end else begin
            n_cal = {1'b0, {(CAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_out) begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire
